// ----- src/hcrm_pkg.sv -----
package hcrm_pkg;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_W-1:0]     cfg_word_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_MIN_HALF_CYCLE = 2'd0;
    localparam cfg_index_t CFG_DC_WINDOW      = 2'd1;

    localparam cfg_word_t MIN_HALF_CYCLE_RESET = 16'd500;
    localparam cfg_word_t DC_WINDOW_RESET      = 16'd10000;

    // result word
    localparam int RMS_W = 16;
    typedef logic [RMS_W-1:0] rms_t;

    // window sequencer
    typedef enum logic [4:0]
    {
        ST_IDLE   = 5'b00001,
        ST_SQUARE = 5'b00010,
        ST_ACCUM  = 5'b00100,
        ST_CALC   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    // divide / root engine phases
    typedef enum logic [2:0]
    {
        PH_IDLE   = 3'b001,
        PH_DIVIDE = 3'b010,
        PH_ROOT   = 3'b100
    } phase_t;

endpackage

// ----- src/hcrm_engine.sv -----
module hcrm_engine #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [2*SAMPLE_BITS+COUNT_BITS-1:0]   sum,
    input  logic [COUNT_BITS-1:0]                 count,
    output logic                                  done,
    output hcrm_pkg::rms_t                        rms
);

    localparam int SUM_W  = 2*SAMPLE_BITS + COUNT_BITS;
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int QUO_W  = 2*ROOT_W;
    localparam int ALU_W  = (ROOT_W + 2 > COUNT_BITS + 1) ? ROOT_W + 2 : COUNT_BITS + 1;
    localparam int STEP_W = $clog2(QUO_W);

    hcrm_pkg::phase_t    phase_reg, phase_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [ALU_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;

    // shared subtract / compare unit
    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic [ALU_W:0]      alu_diff;
    logic                alu_ge;
    logic [ALU_W-1:0]    rem_step;
    logic [SAMPLE_BITS-2:0] rms_sat;

    always_comb
    begin
        if (phase_reg == hcrm_pkg::PH_ROOT)
        begin
            // bring down two radicand bits, trial is 4*root + 1
            alu_a = {rem_reg[ALU_W-3:0], quo_reg[QUO_W-1 -: 2]};
            alu_b = ALU_W'({root_reg, 2'b01});
        end
        else
        begin
            // restoring divide, one quotient bit a cycle
            alu_a = {rem_reg[ALU_W-2:0], quo_reg[QUO_W-1]};
            alu_b = ALU_W'(count);
        end
        alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    end

    assign alu_ge   = ~alu_diff[ALU_W];
    assign rem_step = alu_ge ? alu_diff[ALU_W-1:0] : alu_a;

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        case (phase_reg)
            hcrm_pkg::PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = hcrm_pkg::PH_DIVIDE;
                    step_next  = STEP_W'(QUO_W - 1);
                    quo_next   = QUO_W'(sum);
                    rem_next   = '0;
                end
            end
            hcrm_pkg::PH_DIVIDE:
            begin
                quo_next  = {quo_reg[QUO_W-2:0], alu_ge};
                rem_next  = rem_step;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    // quotient complete, becomes the radicand
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(ROOT_W - 1);
                    phase_next = hcrm_pkg::PH_ROOT;
                end
            end
            hcrm_pkg::PH_ROOT:
            begin
                quo_next  = {quo_reg[QUO_W-3:0], 2'b00};
                rem_next  = rem_step;
                root_next = {root_reg[ROOT_W-2:0], alu_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    phase_next = hcrm_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = hcrm_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hcrm_pkg::PH_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = (phase_reg == hcrm_pkg::PH_ROOT) && (step_reg == '0);

    // root reaches full scale only for an all most-negative window
    assign rms_sat = root_reg[SAMPLE_BITS-1] ? {(SAMPLE_BITS-1){1'b1}}
                                             : root_reg[SAMPLE_BITS-2:0];
    assign rms     = hcrm_pkg::rms_t'(rms_sat);

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> phase_reg == hcrm_pkg::PH_IDLE)
        else $error("engine started while busy");

    a_divide_to_root: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hcrm_pkg::PH_DIVIDE && step_reg == '0) |=>
            phase_reg == hcrm_pkg::PH_ROOT)
        else $error("divide did not hand over to root");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> phase_reg == hcrm_pkg::PH_IDLE)
        else $error("engine did not return to idle after done");

endmodule

// ----- src/half_cycle_rms_meter_core.sv -----
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+----------------------------------
// input    | in        | in_valid / in_ready    | sample (signed), polarity
// result   | out       | out_valid / out_ready  | rms_value
// config   | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a sample that extends the window passes through accept, square and accumulate
// a polarity change that closes nothing passes through accept and square only
// a closing window adds a divide phase and a root phase on the shared subtractor
//   and an emit step; a polarity close starts the engine from square, a dc close
//   from accumulate
// in_ready is high only in idle; a finished word waits in the output register,
//   so the next sample is taken while the result is still unread
// emit stalls while the output register still holds an unread word
// reset clears the window, the polarity and sets both registers to their defaults
module half_cycle_rms_meter_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          polarity,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hcrm_pkg::rms_t                rms_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  hcrm_pkg::cfg_index_t          cfg_index,
    input  hcrm_pkg::cfg_word_t           cfg_data
);

    localparam int SUM_W  = 2*SAMPLE_BITS + COUNT_BITS;
    localparam int PROD_W = 2*SAMPLE_BITS;

    // configuration registers
    hcrm_pkg::cfg_word_t      min_half_reg;
    hcrm_pkg::cfg_word_t      dc_window_reg;

    // sequencer and window state
    hcrm_pkg::state_t         state_reg, state_next;
    logic                     last_pol_reg, last_pol_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;

    // captured input word and square
    logic [SAMPLE_BITS-1:0]   sample_reg;
    logic                     pol_reg;
    logic [PROD_W-1:0]        prod_reg, prod_next;

    // output register
    hcrm_pkg::rms_t           rms_reg, rms_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     in_accept;
    logic [SAMPLE_BITS-1:0]   mag;
    logic [COUNT_BITS-1:0]    count_inc;
    logic [SUM_W-1:0]         sum_acc;
    logic                     dc_hit;
    logic                     enough;
    logic                     eng_start;
    logic [SUM_W-1:0]         eng_sum;
    logic                     eng_done;
    hcrm_pkg::rms_t           eng_rms;

    assign in_ready  = (state_reg == hcrm_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign rms_value = rms_reg;

    // magnitude, most negative value maps to 2^(SAMPLE_BITS-1)
    assign mag = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;

    assign count_inc = count_reg + 1'b1;
    assign sum_acc   = sum_reg + SUM_W'(prod_reg);

    // past the dc window, or counter about to run out
    assign dc_hit = (hcrm_pkg::cfg_word_t'(count_inc) > dc_window_reg)
                 || (count_inc == '1);

    // empty window never divides, even with a zero minimum
    assign enough = (count_reg != '0)
                 && (hcrm_pkg::cfg_word_t'(count_reg) >= min_half_reg);

    // dc close starts the engine on the freshly accumulated sum
    assign eng_sum = (state_reg == hcrm_pkg::ST_ACCUM) ? sum_acc : sum_reg;

    always_comb
    begin
        state_next     = state_reg;
        last_pol_next  = last_pol_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        prod_next      = prod_reg;
        rms_next       = rms_reg;
        out_valid_next = out_valid_reg && !out_ready;
        eng_start      = 1'b0;
        case (state_reg)
            hcrm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hcrm_pkg::ST_SQUARE;
                end
            end
            hcrm_pkg::ST_SQUARE:
            begin
                if (pol_reg != last_pol_reg)
                begin
                    // polarity change: drop the sample, close the half cycle
                    last_pol_next = pol_reg;
                    if (enough)
                    begin
                        eng_start  = 1'b1;
                        state_next = hcrm_pkg::ST_CALC;
                    end
                    else
                    begin
                        sum_next   = '0;
                        count_next = '0;
                        state_next = hcrm_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    prod_next  = mag * mag;
                    state_next = hcrm_pkg::ST_ACCUM;
                end
            end
            hcrm_pkg::ST_ACCUM:
            begin
                sum_next   = sum_acc;
                count_next = count_inc;
                if (dc_hit)
                begin
                    eng_start  = 1'b1;
                    state_next = hcrm_pkg::ST_CALC;
                end
                else
                begin
                    state_next = hcrm_pkg::ST_IDLE;
                end
            end
            hcrm_pkg::ST_CALC:
            begin
                if (eng_done)
                begin
                    state_next = hcrm_pkg::ST_EMIT;
                end
            end
            hcrm_pkg::ST_EMIT:
            begin
                // wait for room in the output register
                if (!out_valid_reg || out_ready)
                begin
                    rms_next       = eng_rms;
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    count_next     = '0;
                    state_next     = hcrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcrm_pkg::ST_IDLE;
            last_pol_reg  <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_pol_reg  <= last_pol_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
            pol_reg    <= polarity;
        end
        prod_reg <= prod_next;
        rms_reg  <= rms_next;
    end

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_half_reg  <= hcrm_pkg::MIN_HALF_CYCLE_RESET;
            dc_window_reg <= hcrm_pkg::DC_WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hcrm_pkg::CFG_MIN_HALF_CYCLE: min_half_reg  <= cfg_data;
                hcrm_pkg::CFG_DC_WINDOW:      dc_window_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // divide and root on the shared subtractor
    hcrm_engine #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (eng_start),
        .sum   (eng_sum),
        .count (count_reg),
        .done  (eng_done),
        .rms   (eng_rms)
    );

    a_idle_count_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hcrm_pkg::ST_IDLE |-> count_reg != '1)
        else $error("window counter left full in idle");

    a_done_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hcrm_pkg::ST_CALC && eng_done) |=> state_reg == hcrm_pkg::ST_EMIT)
        else $error("engine result not taken to emit");

    a_polarity_only_on_square: assert property (@(posedge clk) disable iff (!rst_n)
        (last_pol_reg != $past(last_pol_reg)) |-> $past(state_reg) == hcrm_pkg::ST_SQUARE)
        else $error("stored polarity changed outside the square step");

    a_window_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (count_reg == '0 && sum_reg == '0))
        else $error("window not cleared when a result was loaded");

endmodule
